### hw/rtl/cmcv_pkg.sv
`default_nettype none

package cmcv_pkg;

  localparam int CHIPS_PER_CHAIN = 12;
  localparam int TOTAL_CHIPS     = 768;
  localparam int MAX_CELL_ID     = 47;

  localparam int CID_IN_W   = 8;
  localparam int IDX_W      = 10;
  localparam int VOTE_W     = 6;
  localparam int HALF_CHIPS = TOTAL_CHIPS / 2;
  localparam int SLOT_W     = $clog2(CHIPS_PER_CHAIN);
  localparam int VAL_W      = $clog2(MAX_CELL_ID + 1);
  localparam int CNT_W      = $clog2(CHIPS_PER_CHAIN + 1);
  localparam int TALLY_DEPTH = MAX_CELL_ID + 1;
  localparam int BUF_W      = CID_IN_W + 1;

  function automatic logic id_in_range(input logic [CID_IN_W-1:0] id);
    return (id != '0) && (id <= CID_IN_W'(MAX_CELL_ID));
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cmcv_in_if.sv
`default_nettype none

interface cmcv_in_if import cmcv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CID_IN_W-1:0] cell_id;
  logic                tagged_req;
  logic                start_scan;

  modport source (output valid, cell_id, tagged_req, start_scan, input ready);
  modport sink   (input valid, cell_id, tagged_req, start_scan, output ready);
endinterface

`default_nettype wire

### hw/rtl/cmcv_out_if.sv
`default_nettype none

interface cmcv_out_if import cmcv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  chip_index;
  logic [VOTE_W-1:0] voted_cell_id;
  logic              south_lock;
  logic              north_lock;
  logic              last;

  modport source (output valid, chip_index, voted_cell_id, south_lock, north_lock, last,
                  input ready);
  modport sink   (input valid, chip_index, voted_cell_id, south_lock, north_lock, last,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/chain_majority_cell_id_vote.sv
`default_nettype none

// Chain majority vote: chips enter one per cycle while the block is idle and no
// clearing pass is due; each untagged chip with an id in 1..MAX_CELL_ID bumps its
// tally in a tally memory (one read-modify-write per chip, forwarded between
// back-to-back chips) while the running leader is tracked. After the last chip of
// a chain the block settles the winner, then re-reads the chain buffer and emits
// one result per cycle while the sink is ready, zeroing the used tallies on the
// way. The settle state covers the last chip's tally read-modify-write and the
// first chain buffer read. After reset, and when a scan restart or position wrap
// drops a partial chain that holds votes, a clearing pass over all MAX_CELL_ID+1
// tally entries (48) runs before the next request is taken.
module chain_majority_cell_id_vote import cmcv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cmcv_in_if.sink    in_if,
  cmcv_out_if.source out_if
);

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WIN   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [VAL_W-1:0]  sweep_idx_r, sweep_idx_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [IDX_W-1:0]  base_r, base_nxt;
  logic              dirty_r, dirty_nxt;
  logic              south_r, south_nxt;
  logic              north_r, north_nxt;
  logic [SLOT_W-1:0] k_r, k_nxt;

  logic              p1_vld_r;
  logic [VAL_W-1:0]  p1_id_r;
  logic              fwd_vld_r;
  logic [VAL_W-1:0]  fwd_id_r;
  logic [CNT_W-1:0]  fwd_cnt_r;
  logic [CNT_W-1:0]  best_cnt_r, best_cnt_nxt;
  logic [VAL_W-1:0]  best_val_r, best_val_nxt;

  logic              out_vld_r, out_vld_nxt;
  logic [IDX_W-1:0]  out_idx_r;
  logic [VOTE_W-1:0] out_vote_r;
  logic              out_south_r, out_north_r, out_last_r;

  logic              need_sweep, in_ready, accept, vote_en;
  logic [SLOT_W-1:0] slot_eff;
  logic [IDX_W-1:0]  pos_eff;
  logic              slot_last, pos_last;

  logic [CNT_W-1:0]  cnt_rd, cnt_old, cnt_new;
  logic              leader_upd;

  logic              t_wr_en;
  logic [VAL_W-1:0]  t_wr_addr;
  logic [CNT_W-1:0]  t_wr_data;

  logic [BUF_W-1:0]  buf_rd;
  logic              b_rd_en;
  logic [SLOT_W-1:0] b_rd_addr;
  logic [CID_IN_W-1:0] b_id;
  logic              b_tag;
  logic              emit_load, k_last;
  logic [VAL_W-1:0]  res;
  logic [IDX_W-1:0]  idx;
  logic              bad, south_hit, north_hit;

  assign need_sweep = dirty_r && (in_if.start_scan || (slot_r == '0));
  assign in_ready   = (state_r == ST_IDLE) && !need_sweep;
  assign accept     = in_if.valid && in_ready;
  assign vote_en    = id_in_range(in_if.cell_id) && !in_if.tagged_req;
  assign slot_eff   = in_if.start_scan ? '0 : slot_r;
  assign pos_eff    = in_if.start_scan ? '0 : pos_r;
  assign slot_last  = (slot_eff == SLOT_W'(CHIPS_PER_CHAIN - 1));
  assign pos_last   = (pos_eff == IDX_W'(TOTAL_CHIPS - 1));

  // tally update, forwarded from the previous cycle's write
  assign cnt_old    = (fwd_vld_r && (fwd_id_r == p1_id_r)) ? fwd_cnt_r : cnt_rd;
  assign cnt_new    = cnt_old + CNT_W'(1);
  assign leader_upd = (cnt_new > best_cnt_r) ||
                      ((cnt_new == best_cnt_r) && (p1_id_r < best_val_r));

  assign b_id      = buf_rd[CID_IN_W-1:0];
  assign b_tag     = buf_rd[CID_IN_W];
  assign emit_load = (state_r == ST_EMIT) && (!out_vld_r || out_if.ready);
  assign k_last    = (k_r == SLOT_W'(CHIPS_PER_CHAIN - 1));
  assign res       = (b_id == CID_IN_W'(best_val_r)) ? best_val_r : '0;
  assign idx       = base_r + IDX_W'(k_r);
  assign bad       = (res == '0) && !b_tag;
  assign south_hit = bad && (idx < IDX_W'(HALF_CHIPS));
  assign north_hit = bad && !(idx < IDX_W'(HALF_CHIPS));

  always_comb begin
    t_wr_en   = 1'b0;
    t_wr_addr = p1_id_r;
    t_wr_data = cnt_new;
    priority if (state_r == ST_SWEEP) begin
      t_wr_en   = 1'b1;
      t_wr_addr = sweep_idx_r;
      t_wr_data = '0;
    end else if (p1_vld_r) begin
      t_wr_en = 1'b1;
    end else if (emit_load && id_in_range(b_id)) begin
      t_wr_en   = 1'b1;
      t_wr_addr = b_id[VAL_W-1:0];
      t_wr_data = '0;
    end else begin
      t_wr_en = 1'b0;
    end
  end

  assign b_rd_en   = (state_r == ST_WIN) || (emit_load && !k_last);
  assign b_rd_addr = (state_r == ST_WIN) ? '0 : k_r + SLOT_W'(1);

  cmcv_ram #(.WIDTH(CNT_W), .DEPTH(TALLY_DEPTH)) u_tally (
    .clk     (clk),
    .wr_en   (t_wr_en),
    .wr_addr (t_wr_addr),
    .wr_data (t_wr_data),
    .rd_en   (accept && vote_en),
    .rd_addr (in_if.cell_id[VAL_W-1:0]),
    .rd_data (cnt_rd)
  );

  cmcv_ram #(.WIDTH(BUF_W), .DEPTH(CHIPS_PER_CHAIN)) u_chain_buf (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (slot_eff),
    .wr_data ({in_if.tagged_req, in_if.cell_id}),
    .rd_en   (b_rd_en),
    .rd_addr (b_rd_addr),
    .rd_data (buf_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    sweep_idx_nxt = sweep_idx_r;
    pos_nxt       = pos_r;
    slot_nxt      = slot_r;
    base_nxt      = base_r;
    dirty_nxt     = dirty_r;
    south_nxt     = south_r;
    north_nxt     = north_r;
    k_nxt         = k_r;
    best_cnt_nxt  = best_cnt_r;
    best_val_nxt  = best_val_r;
    out_vld_nxt   = out_vld_r;

    if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end

    if (p1_vld_r && leader_upd) begin
      best_cnt_nxt = cnt_new;
      best_val_nxt = p1_id_r;
    end

    unique case (state_r)
      ST_SWEEP: begin
        sweep_idx_nxt = sweep_idx_r + VAL_W'(1);
        if (sweep_idx_r == VAL_W'(MAX_CELL_ID)) begin
          sweep_idx_nxt = '0;
          dirty_nxt     = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_if.start_scan) begin
            south_nxt = 1'b0;
            north_nxt = 1'b0;
          end
          if (slot_eff == '0) begin
            base_nxt     = pos_eff;
            best_cnt_nxt = '0;
            best_val_nxt = '0;
          end
          if (vote_en) begin
            dirty_nxt = 1'b1;
          end
          pos_nxt  = pos_last ? '0 : pos_eff + IDX_W'(1);
          slot_nxt = (slot_last || pos_last) ? '0 : slot_eff + SLOT_W'(1);
          if (slot_last) begin
            state_nxt = ST_WIN;
          end
        end else if (in_if.valid && need_sweep && !p1_vld_r) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_WIN: begin
        k_nxt     = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load) begin
          out_vld_nxt = 1'b1;
          south_nxt   = south_r | south_hit;
          north_nxt   = north_r | north_hit;
          k_nxt       = k_r + SLOT_W'(1);
          if (k_last) begin
            k_nxt     = '0;
            dirty_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_idx_r <= '0;
      pos_r       <= '0;
      slot_r      <= '0;
      dirty_r     <= 1'b0;
      south_r     <= 1'b0;
      north_r     <= 1'b0;
      k_r         <= '0;
      p1_vld_r    <= 1'b0;
      fwd_vld_r   <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_idx_r <= sweep_idx_nxt;
      pos_r       <= pos_nxt;
      slot_r      <= slot_nxt;
      dirty_r     <= dirty_nxt;
      south_r     <= south_nxt;
      north_r     <= north_nxt;
      k_r         <= k_nxt;
      p1_vld_r    <= accept && vote_en;
      fwd_vld_r   <= p1_vld_r;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_val_r <= best_val_nxt;
    p1_id_r    <= in_if.cell_id[VAL_W-1:0];
    fwd_id_r   <= p1_id_r;
    fwd_cnt_r  <= cnt_new;
    if (emit_load) begin
      out_idx_r   <= idx;
      out_vote_r  <= VOTE_W'(res);
      out_south_r <= south_r | south_hit;
      out_north_r <= north_r | north_hit;
      out_last_r  <= k_last;
    end
  end

  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_vld_r;
  assign out_if.chip_index    = out_idx_r;
  assign out_if.voted_cell_id = out_vote_r;
  assign out_if.south_lock    = out_south_r;
  assign out_if.north_lock    = out_north_r;
  assign out_if.last          = out_last_r;

`ifndef ASSERT_OFF
  a_tally_port_free: assert property (@(posedge clk) disable iff (!rst_n)
    p1_vld_r |-> ((state_r == ST_IDLE) || (state_r == ST_WIN)))
    else $error("tally update overlaps clear or sweep");

  a_final_chip_votes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && slot_last) |=> (state_r == ST_WIN))
    else $error("final chip of chain did not start the vote");

  a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.ready && out_if.last) |=> !out_if.valid)
    else $error("result after end of chain burst");
`endif

endmodule

`default_nettype wire

### hw/rtl/cmcv_ram.sv
`default_nettype none

module cmcv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### tb/chain_majority_cell_id_vote_test.sv
`timescale 1ns / 1ps

module chain_majority_cell_id_vote_test;
  import cmcv_pkg::*;

  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 4 * CHIPS_PER_CHAIN + MAX_CELL_ID + 8;

  class vote_scoreboard;
    typedef struct {
      logic [IDX_W-1:0]  chip_index;
      logic [VOTE_W-1:0] voted;
      logic              south;
      logic              north;
      logic              last;
    } chip_verdict_t;

    chip_verdict_t       verdict_q[$];
    logic [CID_IN_W-1:0] chain_ids[CHIPS_PER_CHAIN];
    bit                  chain_tagged[CHIPS_PER_CHAIN];
    int unsigned         position;
    bit                  south_flag;
    bit                  north_flag;
    int                  errors;

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    // most frequent untagged id in 1..MAX_CELL_ID, ties to the smaller id, 0 if none
    function int unsigned chain_winner();
      int unsigned tally[256];
      int unsigned best_n;
      int unsigned best_v;
      best_n = 0;
      best_v = 0;
      foreach (tally[v]) tally[v] = 0;
      for (int k = 0; k < CHIPS_PER_CHAIN; k++)
        if (!chain_tagged[k]) tally[chain_ids[k]]++;
      for (int unsigned v = 1; v <= MAX_CELL_ID; v++) begin
        if (tally[v] > best_n) begin
          best_n = tally[v];
          best_v = v;
        end
      end
      return best_v;
    endfunction

    function void note_request(logic [CID_IN_W-1:0] cid, logic tag, logic start);
      int unsigned   slot;
      int unsigned   winner;
      int unsigned   idx;
      chip_verdict_t v;
      if (start) begin
        position   = 0;
        south_flag = 0;
        north_flag = 0;
      end
      slot = position % CHIPS_PER_CHAIN;
      chain_ids[slot]    = cid;
      chain_tagged[slot] = tag;
      if (slot == CHIPS_PER_CHAIN - 1) begin
        winner = chain_winner();
        for (int k = 0; k < CHIPS_PER_CHAIN; k++) begin
          idx     = position - slot + k;
          v.voted = (chain_ids[k] == winner) ? VOTE_W'(winner) : '0;
          if (v.voted == '0 && !chain_tagged[k]) begin
            if (idx < HALF_CHIPS) south_flag = 1;
            else north_flag = 1;
          end
          v.chip_index = IDX_W'(idx);
          v.south      = south_flag;
          v.north      = north_flag;
          v.last       = (k == CHIPS_PER_CHAIN - 1);
          verdict_q    = {verdict_q, v};
        end
      end
      position = (position + 1) % TOTAL_CHIPS;
    endfunction

    function void mismatch(string field, logic [IDX_W-1:0] chip, int unsigned want,
                           int unsigned got);
      if (errors < 25)
        $display("%0t: chip %0d %s expected %0d actual %0d", $time, chip, field, want, got);
      errors++;
    endfunction

    function void check_result(logic [IDX_W-1:0] chip, logic [VOTE_W-1:0] voted,
                               logic south, logic north, logic last);
      chip_verdict_t want;
      if (verdict_q.size() == 0) begin
        if (errors < 25)
          $display("%0t: unexpected result chip %0d voted %0d", $time, chip, voted);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      if (chip !== want.chip_index)
        mismatch("chip_index", want.chip_index, 32'(want.chip_index), 32'(chip));
      if (voted !== want.voted)
        mismatch("voted_cell_id", want.chip_index, 32'(want.voted), 32'(voted));
      if (south !== want.south)
        mismatch("south_lock", want.chip_index, 32'(want.south), 32'(south));
      if (north !== want.north)
        mismatch("north_lock", want.chip_index, 32'(want.north), 32'(north));
      if (last !== want.last)
        mismatch("last", want.chip_index, 32'(want.last), 32'(last));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cmcv_in_if  in_if();
  cmcv_out_if out_if();

  chain_majority_cell_id_vote u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  vote_scoreboard sb = new();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold_left;
  int unsigned tx_pos;
  int unsigned chips_sent;
  int unsigned stall_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // request and result monitors
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_request(in_if.cell_id, in_if.tagged_req, in_if.start_scan);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.chip_index, out_if.voted_cell_id, out_if.south_lock,
                      out_if.north_lock, out_if.last);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_if.ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_chip(logic [CID_IN_W-1:0] cid, logic tag, logic start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.cell_id    <= cid;
    in_if.tagged_req <= tag;
    in_if.start_scan <= start;
    do @(posedge clk); while (!in_if.ready);
    tx_pos = start ? 1 : (tx_pos + 1) % TOTAL_CHIPS;
    chips_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // completes the current chain (or a fresh one on start) with clustered ids
  task automatic send_chain(bit with_start);
    logic [CID_IN_W-1:0] favorites[3];
    int unsigned         n;
    int unsigned         r;
    int unsigned         tag_pct;
    logic [CID_IN_W-1:0] cid;
    n = with_start ? CHIPS_PER_CHAIN : CHIPS_PER_CHAIN - tx_pos % CHIPS_PER_CHAIN;
    foreach (favorites[i]) favorites[i] = CID_IN_W'($urandom_range(1, MAX_CELL_ID));
    if ($urandom_range(9) == 0) favorites[0] = CID_IN_W'(MAX_CELL_ID);
    if ($urandom_range(9) == 0) favorites[1] = CID_IN_W'(1);
    tag_pct = ($urandom_range(9) == 0) ? 100 : 20;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 55)      cid = favorites[$urandom_range(2)];
      else if (r < 70) cid = CID_IN_W'($urandom_range(1, MAX_CELL_ID));
      else if (r < 80) cid = '0;
      else             cid = CID_IN_W'($urandom_range(MAX_CELL_ID + 1, 255));
      send_chip(cid, $urandom_range(99) < tag_pct, with_start && i == 0);
    end
  endtask

  task automatic random_traffic(int unsigned n_items);
    int unsigned first;
    int unsigned r;
    first = chips_sent;
    while (chips_sent - first < n_items) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // broken chain: a random partial, completed by a later chain or dropped by a later start
        repeat ($urandom_range(1, CHIPS_PER_CHAIN - 1))
          send_chip(CID_IN_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
      end else begin
        send_chain(r < 20);
      end
    end
  endtask

  initial begin
    logic [CID_IN_W-1:0] tie_chain[CHIPS_PER_CHAIN];
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cell_id    = '0;
    in_if.tagged_req = 1'b0;
    in_if.start_scan = 1'b0;
    out_if.ready     = 1'b0;
    tx_idle_pct      = 15;
    rx_idle_pct      = 45;
    rx_hold_left     = 0;
    tx_pos           = 0;
    chips_sent       = 0;
    stall_cycles     = 0;
    tie_chain = '{8'd5, 8'd3, 8'd5, 8'd3, 8'd0, 8'd255, 8'd48, 8'd47, 8'd1, 8'd7, 8'd7, 8'd7};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // tie between 3 and 5 goes to 3; out-of-range ids; tagged 7s outvoted by nothing
    for (int k = 0; k < CHIPS_PER_CHAIN; k++)
      send_chip(tie_chain[k], k >= 9, k == 0);
    // partial chain with votes, dropped by a restart
    send_chip(8'd20, 1'b0, 1'b0);
    // all tagged: no winner, locks stay clear
    for (int k = 0; k < CHIPS_PER_CHAIN; k++)
      send_chip((k == 4) ? 8'd0 : 8'd9, 1'b1, k == 0);

    random_traffic(60);
    wait_drained();

    tx_idle_pct  = 45;
    rx_idle_pct  = 15;
    rx_hold_left = LONG_HOLD;
    random_traffic(60);
    wait_drained();

    // short run without idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_chain(1'b1);
    send_chain(1'b0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
